@@ hw/rtl/pee_pkg.sv @@
// Shared types, character codes, operation and status codes of the postfix evaluator.
package pee_pkg;

	// Default sizes
	localparam int STACK_DEPTH_DEF = 16;
	localparam int VALUE_WIDTH_DEF = 32;

	// Fixed field widths of the ports
	localparam int CH_W     = 8;
	localparam int OUT_W    = 32;
	localparam int STATUS_W = 3;
	localparam int DIGIT_W  = 4;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Characters
	localparam logic [CH_W-1:0] CH_0     = 8'h30;
	localparam logic [CH_W-1:0] CH_9     = 8'h39;
	localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
	localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

	// Classified operation
	typedef logic [2:0] op_t;
	localparam op_t OP_NONE  = 3'd0;
	localparam op_t OP_DIGIT = 3'd1;
	localparam op_t OP_ADD   = 3'd2;
	localparam op_t OP_SUB   = 3'd3;
	localparam op_t OP_MUL   = 3'd4;
	localparam op_t OP_DIV   = 3'd5;

	// Result status
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_UNDER = 3'd1;
	localparam status_t ST_OVER  = 3'd2;
	localparam status_t ST_DIVZ  = 3'd3;
	localparam status_t ST_EMPTY = 3'd4;

	// Port items
	typedef struct packed {
		logic [CH_W-1:0] ch;
		logic            last;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] value;
		status_t                 status;
	} out_item_t;

	// Classified item held in the queue
	typedef struct packed {
		op_t                op;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} op_item_t;

	// Request to the multiply/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} mdu_req_t;

endpackage

@@ hw/rtl/pee_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/pee_front.sv @@
// Front end: classifies incoming characters and queues them for the back end.
module pee_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pee_pkg::in_item_t  item,
	input  logic               q_pop,
	output logic               q_empty,
	output pee_pkg::op_item_t  q_head
);
	import pee_pkg::*;

	localparam int PtrW = $clog2(QUEUE_DEPTH);
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);

	op_item_t        entry_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	op_item_t        cls;
	logic            wr_en;
	logic            rd_en;

	// Character classification
	always_comb begin
		cls.op    = OP_NONE;
		cls.digit = '0;
		cls.last  = item.last;
		if (item.ch >= CH_0 && item.ch <= CH_9) begin
			cls.op    = OP_DIGIT;
			cls.digit = DIGIT_W'(item.ch - CH_0);
		end else if (item.ch == CH_PLUS) begin
			cls.op = OP_ADD;
		end else if (item.ch == CH_MINUS) begin
			cls.op = OP_SUB;
		end else if (item.ch == CH_STAR) begin
			cls.op = OP_MUL;
		end else if (item.ch == CH_SLASH) begin
			cls.op = OP_DIV;
		end
	end

	assign full    = (count_q == CntW'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign wr_en   = push && !full;
	assign rd_en   = q_pop && !q_empty;
	assign q_head  = entry_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_q[wr_ptr_q] <= cls;
		end
	end

	// Queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hw/rtl/pee_mdu.sv @@
// Shared sequential unit: shift-add multiply and restoring signed divide.
module pee_mdu #(
	parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  pee_pkg::mdu_req_t      req,
	input  logic [VALUE_WIDTH-1:0] lhs,
	input  logic [VALUE_WIDTH-1:0] rhs,
	output logic                   done,
	output logic [VALUE_WIDTH-1:0] res
);
	import pee_pkg::*;

	localparam int StepW = $clog2(VALUE_WIDTH);

	logic                   busy_q;
	logic                   done_q;
	logic                   div_q;
	logic                   neg_q;
	logic [StepW-1:0]       step_q;
	logic [VALUE_WIDTH-1:0] x_q;
	logic [VALUE_WIDTH-1:0] y_q;
	logic [VALUE_WIDTH-1:0] z_q;
	logic [VALUE_WIDTH-1:0] lhs_mag;
	logic [VALUE_WIDTH-1:0] rhs_mag;
	logic [VALUE_WIDTH:0]   rem_sh;
	logic [VALUE_WIDTH:0]   rem_sub;
	logic                   qbit;

	// Operand magnitudes for division
	assign lhs_mag = lhs[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - lhs) : lhs;
	assign rhs_mag = rhs[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - rhs) : rhs;

	// One restoring step
	assign rem_sh  = {z_q, x_q[VALUE_WIDTH-1]};
	assign rem_sub = rem_sh - {1'b0, y_q};
	assign qbit    = (rem_sh >= {1'b0, y_q});

	// Iteration: one bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == StepW'(VALUE_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			neg_q <= lhs[VALUE_WIDTH-1] ^ rhs[VALUE_WIDTH-1];
			z_q   <= '0;
			if (req.is_div) begin
				x_q <= lhs_mag;
				y_q <= rhs_mag;
			end else begin
				x_q <= rhs;
				y_q <= lhs;
			end
		end else if (busy_q) begin
			if (div_q) begin
				z_q <= qbit ? rem_sub[VALUE_WIDTH-1:0] : rem_sh[VALUE_WIDTH-1:0];
				x_q <= {x_q[VALUE_WIDTH-2:0], qbit};
			end else begin
				if (x_q[0]) begin
					z_q <= z_q + y_q;
				end
				y_q <= {y_q[VALUE_WIDTH-2:0], 1'b0};
				x_q <= {1'b0, x_q[VALUE_WIDTH-1:1]};
			end
		end
	end

	assign done = done_q;
	assign res  = div_q ? (neg_q ? (VALUE_WIDTH'(0) - x_q) : x_q) : z_q;

endmodule

@@ hw/rtl/pee_back.sv @@
// Back end: operand stack, sequencing of operations and the result register.
module pee_back #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  pee_pkg::op_item_t  q_head,
	output logic               q_pop,
	output logic               empty,
	input  logic               pop,
	output pee_pkg::out_item_t result
);
	import pee_pkg::*;

	localparam int CntW  = $clog2(STACK_DEPTH + 1);
	localparam int AddrW = $clog2(STACK_DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_CALC = 2'd2;

	logic [1:0]             state_q, state_d;
	logic [CntW-1:0]        cnt_q, cnt_d;
	status_t                err_q, err_d;
	logic [VALUE_WIDTH-1:0] top_q, top_d;
	op_t                    op_q;
	logic                   last_q;
	logic                   out_valid_q;
	out_item_t              out_q, out_d;

	logic                   take;
	logic                   cur_last;
	logic                   done;
	logic                   out_set;
	logic [CntW-1:0]        cnt_m2;
	status_t                fin_status;

	logic                   ram_we;
	logic [AddrW-1:0]       ram_waddr;
	logic [VALUE_WIDTH-1:0] ram_wdata;
	logic                   ram_re;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	mdu_req_t               mdu_req;
	logic                   mdu_done;
	logic [VALUE_WIDTH-1:0] mdu_res;

	// Keeps the first error of an expression
	function automatic status_t keep_err(status_t cur, status_t code);
		keep_err = (cur == ST_OK) ? code : cur;
	endfunction

	// A last item is taken only when the result register is free
	assign take     = (state_q == S_IDLE) && !q_empty && !(q_head.last && out_valid_q);
	assign q_pop    = take;
	assign cur_last = (state_q == S_IDLE) ? q_head.last : last_q;
	assign cnt_m2   = cnt_q - CntW'(2);

	// Stack memory: entries below the count; the top entry is mirrored in top_q
	pee_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(cnt_m2[AddrW-1:0]),
		.rdata(ram_rdata)
	);

	pee_mdu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mdu_req),
		.lhs   (ram_rdata),
		.rhs   (top_q),
		.done  (mdu_done),
		.res   (mdu_res)
	);

	// Sequencer and next-state logic
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		err_d     = err_q;
		top_d     = top_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_m2[AddrW-1:0];
		ram_wdata = top_q;
		ram_re    = 1'b0;
		mdu_req   = '0;
		done      = 1'b0;
		out_set   = 1'b0;
		out_d     = out_q;
		fin_status = ST_OK;

		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					unique case (q_head.op)
						OP_DIGIT: begin
							done = 1'b1;
							if (cnt_q == CntW'(STACK_DEPTH)) begin
								err_d = keep_err(err_q, ST_OVER);
							end else begin
								ram_we    = 1'b1;
								ram_waddr = cnt_q[AddrW-1:0];
								ram_wdata = VALUE_WIDTH'(q_head.digit);
								top_d     = VALUE_WIDTH'(q_head.digit);
								cnt_d     = cnt_q + 1'b1;
							end
						end
						OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
							if (cnt_q < CntW'(2)) begin
								err_d = keep_err(err_q, ST_UNDER);
								done  = 1'b1;
							end else begin
								ram_re  = 1'b1;
								state_d = S_READ;
							end
						end
						default: begin
							done = 1'b1;
						end
					endcase
				end
			end
			S_READ: begin
				unique case (op_q)
					OP_ADD: begin
						top_d = ram_rdata + top_q;
						done  = 1'b1;
					end
					OP_SUB: begin
						top_d = ram_rdata - top_q;
						done  = 1'b1;
					end
					OP_MUL: begin
						mdu_req.start = 1'b1;
						state_d       = S_CALC;
					end
					OP_DIV: begin
						if (top_q == '0) begin
							err_d = keep_err(err_q, ST_DIVZ);
							done  = 1'b1;
						end else begin
							mdu_req.start  = 1'b1;
							mdu_req.is_div = 1'b1;
							state_d        = S_CALC;
						end
					end
					default: begin
						done = 1'b1;
					end
				endcase
				// Pop both operands and push the result
				if (done && (op_q == OP_ADD || op_q == OP_SUB)) begin
					ram_we    = 1'b1;
					ram_wdata = top_d;
					cnt_d     = cnt_q - 1'b1;
				end
			end
			S_CALC: begin
				if (mdu_done) begin
					top_d     = mdu_res;
					ram_we    = 1'b1;
					ram_wdata = mdu_res;
					cnt_d     = cnt_q - 1'b1;
					done      = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// End of item; the last one yields a result and clears the expression
		if (done) begin
			state_d = S_IDLE;
			if (cur_last) begin
				if (err_d != ST_OK) begin
					fin_status = err_d;
				end else if (cnt_d == '0) begin
					fin_status = ST_EMPTY;
				end else begin
					fin_status = ST_OK;
				end
				out_set      = 1'b1;
				out_d.status = fin_status;
				out_d.value  = (fin_status == ST_OK) ? OUT_W'($signed(top_d)) : '0;
				cnt_d        = '0;
				err_d        = ST_OK;
			end
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			err_q   <= err_d;
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (take) begin
			op_q   <= q_head.op;
			last_q <= q_head.last;
		end
		if (out_set) begin
			out_q <= out_d;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

	// A result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_set |-> !out_valid_q)
		else $error("result register overwritten");

	// Stack count stays within the memory
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// The shared unit finishes only while the sequencer waits for it
	a_mdu_done: assert property (@(posedge clk) disable iff (!arst_n)
		mdu_done |-> (state_q == S_CALC))
		else $error("unexpected multiply/divide completion");

	// Operand read data is used only after a read was issued
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> $past(ram_re))
		else $error("operand state without stack read");

endmodule

@@ hw/rtl/postfix_expression_evaluator.sv @@
// Top level of the postfix expression evaluator.
//
// Input channel: one ASCII character per item (push/full). Digits push their
// value, + - * / combine the two top values, other characters are ignored.
// An item with last set ends the expression and yields one result item
// (value, status) on the result channel (empty/pop); other items yield none.
//
// Items pass a classifier into a four-entry queue; the back end drains it.
// In the back end a digit, an ignored character or an operator that underflows
// is done in the idle state; + and - and / by zero add a state that reads the
// stack memory; other * and / then wait in a calculate state for the shared
// one-bit-per-cycle multiply/divide unit.
// A result is registered and visible in the cycle after its item leaves the back end.
//
// Reset clears the queue, stack count, sticky error and result valid flag.
// Stack memory contents are not cleared; entries are written before read.
// While a result waits, the queue keeps taking items and the back end keeps
// working; only an item with last set waits for the result register to free.
module postfix_expression_evaluator #(
	parameter int STACK_DEPTH = pee_pkg::STACK_DEPTH_DEF,
	parameter int VALUE_WIDTH = pee_pkg::VALUE_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  pee_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output pee_pkg::out_item_t result
);
	import pee_pkg::*;

	logic     q_pop;
	logic     q_empty;
	op_item_t q_head;

	// Front end: classify and queue
	pee_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_pop  (q_pop),
		.q_empty(q_empty),
		.q_head (q_head)
	);

	// Back end: stack, arithmetic and result register
	pee_back #(
		.STACK_DEPTH(STACK_DEPTH),
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_head (q_head),
		.q_pop  (q_pop),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

endmodule
